// ----- src/psc_pkg.sv -----
// ----------------------------------------------------------------------------
// psc_pkg
// Shared types for the PID speed controller: datapath operations and the
// command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package psc_pkg;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_ERR,
    OP_MUL1,
    OP_RCPH,
    OP_RCPL,
    OP_RCPC,
    OP_RCPF,
    OP_RCPG,
    OP_INT,
    OP_MUL2,
    OP_DIV2,
    OP_DER,
    OP_MP,
    OP_MI,
    OP_MD,
    OP_ACC,
    OP_OUT
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic div_done;
  } status_t;

  localparam int CFG_W = 32;
  localparam int IDX_W = 3;

  localparam logic [IDX_W-1:0] REG_TARGET = 3'd0;
  localparam logic [IDX_W-1:0] REG_GAIN_P = 3'd1;
  localparam logic [IDX_W-1:0] REG_GAIN_I = 3'd2;
  localparam logic [IDX_W-1:0] REG_GAIN_D = 3'd3;
  localparam logic [IDX_W-1:0] REG_BASE   = 3'd4;
  localparam logic [IDX_W-1:0] REG_DEAD   = 3'd5;
  localparam logic [IDX_W-1:0] REG_THRESH = 3'd6;
  localparam logic [IDX_W-1:0] REG_ILIMIT = 3'd7;

  // integral increment: (64*e*dt + 7812) / 15625, by reciprocal 2^44/15625
  localparam logic [41:0] INC_BIAS  = 42'd7812;
  localparam logic [13:0] INC_DIV   = 14'd15625;
  localparam logic [30:0] INC_RECIP = 31'd1125899906;

endpackage

// ----- src/psc_div.sv -----
// ----------------------------------------------------------------------------
// psc_div
// Restoring divider, one quotient bit per cycle, 48-bit dividend by a
// 20-bit divisor. Pulses done with the quotient valid.
// ----------------------------------------------------------------------------
module psc_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [47:0] dividend,
  input  logic [19:0] divisor,
  output logic        done,
  output logic [47:0] quotient
);
  logic        busy;
  logic [5:0]  cnt;
  logic [19:0] rem;
  logic [20:0] rem_s;
  logic [20:0] rem_d;
  logic        qbit;

  assign rem_s = {rem, quotient[47]};
  assign rem_d = rem_s - {1'b0, divisor};
  assign qbit  = (rem_s >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd47) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
    end else if (busy) begin
      quotient <= {quotient[46:0], qbit};
      rem      <= qbit ? rem_d[19:0] : rem_s[19:0];
    end
  end
endmodule

// ----- src/psc_dpath.sv -----
// ----------------------------------------------------------------------------
// psc_dpath
// Datapath: configuration registers, loop state, one shared 33x33 multiplier,
// the divider and the output register.
// ----------------------------------------------------------------------------
module psc_dpath (
  input  logic                            clk,
  input  logic                            rst,
  input  psc_pkg::cmd_t                   cmd,
  output psc_pkg::status_t                status,
  input  logic                            cfg_write,
  input  logic [psc_pkg::IDX_W-1:0]       cfg_index,
  input  logic [psc_pkg::CFG_W-1:0]       cfg_data,
  input  logic signed [15:0]              measured_speed,
  input  logic [19:0]                     elapsed_us,
  output logic [16:0]                     pid_term,
  output logic [16:0]                     drive_level
);
  import psc_pkg::*;

  logic [14:0] target_speed, deadband, windup_reset_threshold;
  logic [31:0] gain_p, gain_i, gain_d;
  logic [16:0] base_level;
  logic [20:0] integral_limit;

  logic signed [15:0] speed;
  logic [19:0]        dt;
  logic signed [17:0] err, prev_err;
  logic [16:0]        mag;
  logic               big;
  logic signed [29:0] integ_w;
  logic signed [22:0] error_integral;
  logic               dneg;
  logic signed [31:0] deriv;
  logic signed [65:0] mprod;
  logic signed [47:0] acc;
  logic [41:0]        rz;
  logic [51:0]        rhi;
  logic [28:0]        q0, qm;

  logic signed [32:0] ma, mb;
  logic signed [17:0] e_new;
  logic [16:0]        e_mag;
  logic signed [18:0] diff;
  logic [17:0]        diff_mag;
  logic signed [29:0] i_sum, i_lim;
  logic signed [65:0] r20_full, r32_full;
  logic signed [47:0] r20, r32;
  logic [41:0]        inc_z, r_rem;
  logic [51:0]        r_sum;
  logic [47:0]        div_dividend;
  logic [19:0]        div_divisor;
  logic               div_start;
  logic [47:0]        quo;
  logic [30:0]        q_sat;
  logic [17:0]        drive_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_speed           <= 15'd1600;
      gain_p                 <= 32'd4294967;
      gain_i                 <= 32'd2147484;
      gain_d                 <= 32'd214748;
      base_level             <= 17'd26214;
      deadband               <= 15'd80;
      windup_reset_threshold <= 15'd640;
      integral_limit         <= 21'd1310720;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_TARGET: target_speed           <= cfg_data[14:0];
        REG_GAIN_P: gain_p                 <= cfg_data;
        REG_GAIN_I: gain_i                 <= cfg_data;
        REG_GAIN_D: gain_d                 <= cfg_data;
        REG_BASE:   base_level             <= cfg_data[16:0];
        REG_DEAD:   deadband               <= cfg_data[14:0];
        REG_THRESH: windup_reset_threshold <= cfg_data[14:0];
        REG_ILIMIT: integral_limit         <= cfg_data[20:0];
        default: ;
      endcase
    end
  end

  assign e_new    = $signed({3'b000, target_speed}) - 18'(speed);
  assign e_mag    = e_new[17] ? 17'(-e_new) : e_new[16:0];
  assign diff     = 19'(err) - 19'(prev_err);
  assign diff_mag = diff[18] ? 18'(-diff) : diff[17:0];
  assign i_sum    = big ? 30'sd0 : (err[17] ? integ_w - $signed({1'b0, qm})
                                            : integ_w + $signed({1'b0, qm}));
  assign i_lim    = (i_sum > $signed({9'd0, integral_limit})) ? $signed({9'd0, integral_limit}) :
                    (i_sum < -$signed({9'd0, integral_limit})) ?
                    -$signed({9'd0, integral_limit}) : i_sum;
  assign r20_full = (mprod + (66'sd1 <<< 19)) >>> 20;
  assign r32_full = (mprod + (66'sd1 <<< 31)) >>> 32;
  assign r20      = r20_full[47:0];
  assign r32      = r32_full[47:0];
  assign q_sat    = (quo > 48'h7FFF_FFFF) ? 31'h7FFF_FFFF : quo[30:0];

  // rounded increment: quotient estimate from two partial products, then
  // one remainder check lifts it by one where needed
  assign inc_z    = {mprod[35:0], 6'd0} + INC_BIAS;
  assign r_sum    = rhi + {21'd0, mprod[51:21]};
  assign r_rem    = rz - mprod[41:0];

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (cmd.op)
      OP_MUL1: begin ma = 33'({16'd0, mag}); mb = 33'({13'd0, dt}); end
      OP_RCPH: begin ma = {12'd0, inc_z[41:21]}; mb = {2'b00, INC_RECIP}; end
      OP_RCPL: begin ma = {12'd0, rz[20:0]}; mb = {2'b00, INC_RECIP}; end
      OP_RCPF: begin ma = {4'd0, q0}; mb = {19'd0, INC_DIV}; end
      OP_MUL2: begin ma = 33'({15'd0, diff_mag}); mb = 33'sd1000000; end
      OP_MP:   begin ma = $signed({1'b0, gain_p}); mb = 33'(err); end
      OP_MI:   begin ma = $signed({1'b0, gain_i}); mb = 33'(error_integral); end
      OP_MD:   begin ma = $signed({1'b0, gain_d}); mb = 33'(deriv); end
      default: ;
    endcase
  end

  assign div_start    = (cmd.op == OP_DIV2);
  assign div_dividend = mprod[47:0];
  assign div_divisor  = dt;

  psc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (status.div_done),
    .quotient (quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      error_integral <= '0;
      prev_err       <= '0;
    end else begin
      if (cmd.op == OP_INT) error_integral <= i_lim[22:0];
      if (cmd.op == OP_DER) prev_err <= err;
    end
  end

  assign drive_sum = {1'b0, base_level} + {1'b0, (acc < 0) ? 17'd0 :
                     (acc > 48'sd65536) ? 17'd65536 : acc[16:0]};

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        speed <= measured_speed;
        dt    <= elapsed_us;
      end
      OP_ERR: begin
        if (e_mag < {2'b00, deadband}) begin
          err     <= '0;
          mag     <= '0;
          integ_w <= '0;
          big     <= 1'b0;
        end else begin
          err     <= e_new;
          mag     <= e_mag;
          integ_w <= 30'(error_integral);
          big     <= e_mag > {2'b00, windup_reset_threshold};
        end
      end
      OP_MUL1: mprod <= ma * mb;
      OP_RCPH: begin
        rz    <= inc_z;
        mprod <= ma * mb;
      end
      OP_RCPL: begin
        rhi   <= mprod[51:0];
        mprod <= ma * mb;
      end
      OP_RCPC: q0 <= r_sum[51:23];
      OP_RCPF: mprod <= ma * mb;
      OP_RCPG: qm <= (r_rem >= {28'd0, INC_DIV}) ? q0 + 29'd1 : q0;
      OP_MUL2: begin
        mprod <= ma * mb;
        dneg  <= diff[18];
      end
      OP_DER: begin
        if (dt == 20'd0) deriv <= '0;
        else deriv <= dneg ? -$signed({1'b0, q_sat}) : $signed({1'b0, q_sat});
      end
      OP_MP: mprod <= ma * mb;
      OP_MI: begin
        acc   <= r20;
        mprod <= ma * mb;
      end
      OP_MD: begin
        acc   <= acc + r32;
        mprod <= ma * mb;
      end
      OP_ACC: acc <= acc + r20;
      OP_OUT: begin
        pid_term    <= drive_sum[16:0] - base_level;
        drive_level <= (drive_sum > 18'd65536) ? 17'd65536 : drive_sum[16:0];
      end
      default: ;
    endcase
  end
endmodule

// ----- src/psc_ctrl.sv -----
// ----------------------------------------------------------------------------
// psc_ctrl
// Controller: sequences one transaction through the datapath and owns the
// channel handshakes.
// ----------------------------------------------------------------------------
module psc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output psc_pkg::cmd_t     cmd,
  input  psc_pkg::status_t  status
);
  import psc_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_ERR, S_MUL1, S_RCPH, S_RCPL, S_RCPC, S_RCPF, S_RCPG, S_INT,
    S_MUL2, S_DIV2, S_WAIT2, S_DER, S_MP, S_MI, S_MD, S_ACC, S_FIN
  } state_t;

  state_t state;
  logic   fin_go;

  assign in_ready = (state == S_IDLE);
  assign fin_go   = (state == S_FIN) && (!out_valid || out_ready);

  always_comb begin
    cmd.op = OP_NONE;
    unique case (state)
      S_IDLE:  if (in_valid) cmd.op = OP_LOAD;
      S_ERR:   cmd.op = OP_ERR;
      S_MUL1:  cmd.op = OP_MUL1;
      S_RCPH:  cmd.op = OP_RCPH;
      S_RCPL:  cmd.op = OP_RCPL;
      S_RCPC:  cmd.op = OP_RCPC;
      S_RCPF:  cmd.op = OP_RCPF;
      S_RCPG:  cmd.op = OP_RCPG;
      S_INT:   cmd.op = OP_INT;
      S_MUL2:  cmd.op = OP_MUL2;
      S_DIV2:  cmd.op = OP_DIV2;
      S_DER:   cmd.op = OP_DER;
      S_MP:    cmd.op = OP_MP;
      S_MI:    cmd.op = OP_MI;
      S_MD:    cmd.op = OP_MD;
      S_ACC:   cmd.op = OP_ACC;
      S_FIN:   if (fin_go) cmd.op = OP_OUT;
      default: cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE:  if (in_valid) state <= S_ERR;
        S_ERR:   state <= S_MUL1;
        S_MUL1:  state <= S_RCPH;
        S_RCPH:  state <= S_RCPL;
        S_RCPL:  state <= S_RCPC;
        S_RCPC:  state <= S_RCPF;
        S_RCPF:  state <= S_RCPG;
        S_RCPG:  state <= S_INT;
        S_INT:   state <= S_MUL2;
        S_MUL2:  state <= S_DIV2;
        S_DIV2:  state <= S_WAIT2;
        S_WAIT2: if (status.div_done) state <= S_DER;
        S_DER:   state <= S_MP;
        S_MP:    state <= S_MI;
        S_MI:    state <= S_MD;
        S_MD:    state <= S_ACC;
        S_ACC:   state <= S_FIN;
        S_FIN: begin
          if (fin_go) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second transaction taken while busy");

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    status.div_done |-> (state == S_WAIT2))
    else $error("divider finished outside the wait state");

  a_out_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_FIN)
    else $error("result raised outside the final step");
endmodule

// ----- src/pid_speed_controller.sv -----
// ----------------------------------------------------------------------------
// pid_speed_controller
// PID wheel speed loop with deadband and anti-windup.
//
// Input channel (in_valid/in_ready) carries measured_speed and elapsed_us;
// output channel (out_valid/out_ready) returns pid_term and drive_level,
// one result per input transaction. Gains, target and limits are written
// through cfg_write/cfg_index/cfg_data, by the user only while the block
// is idle; the block itself does not enforce it. One transaction at a time:
// from acceptance to result, the sequence waits on the bit-serial divider
// for the derivative and otherwise runs multiply, reciprocal and clamp
// steps on the shared multiplier, and finishes before the next is taken.
// A new transaction is taken as soon as the sequence returns to idle, even
// while the previous result still waits in the output register; if the
// receiver stalls, the next result waits in its final step until the
// register frees. Synchronous reset restores the default register values,
// clears the integral and previous error, and empties the output register.
// ----------------------------------------------------------------------------
module pid_speed_controller (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [psc_pkg::IDX_W-1:0]   cfg_index,
  input  logic [psc_pkg::CFG_W-1:0]   cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [15:0]          measured_speed,
  input  logic [19:0]                 elapsed_us,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [16:0]                 pid_term,
  output logic [16:0]                 drive_level
);
  import psc_pkg::*;

  cmd_t    cmd;
  status_t status;

  psc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

  psc_dpath u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .measured_speed (measured_speed),
    .elapsed_us     (elapsed_us),
    .pid_term       (pid_term),
    .drive_level    (drive_level)
  );
endmodule

// ----- test/pid_drive_checker.sv -----
// ----------------------------------------------------------------------------
// pid_drive_checker
// Watches the register port and both channels of the PID speed controller.
// It keeps its own copy of the registers, the integral and the previous
// error, works out pid_term and drive_level for each accepted input
// transaction and compares every accepted result with the oldest one due.
// ----------------------------------------------------------------------------
module pid_drive_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [psc_pkg::IDX_W-1:0] cfg_index,
  input  logic [psc_pkg::CFG_W-1:0] cfg_data,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic signed [15:0]        measured_speed,
  input  logic [19:0]               elapsed_us,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic [16:0]               pid_term,
  input  logic [16:0]               drive_level,
  output int                        errors,
  output int                        outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import psc_pkg::*;

  typedef struct packed {
    logic [16:0] pid;
    logic [16:0] drive;
  } drive_t;

  longint target, gain_p, gain_i, gain_d, base, dead, thresh, ilimit;
  longint integral, prev_err;
  drive_t drive_due[$];

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint clampl(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic drive_t predict_drive(logic signed [15:0] spd, logic [19:0] dt);
    longint err, integ, m, deriv, diff, q, pt, it, dterm, pid;
    drive_t r;
    err = target - longint'(spd);
    integ = integral;
    if (mag(err) < dead) begin
      err = 0;
      integ = 0;
    end
    if (mag(err) > thresh) begin
      integ = 0;
    end else begin
      m = (mag(err) * longint'(dt) * 4096 + 500000) / 1000000;
      integ = clampl(integ + (err < 0 ? -m : m), -ilimit, ilimit);
    end
    deriv = 0;
    if (dt != 0) begin
      diff = err - prev_err;
      q = mag(diff) * 1000000 / longint'(dt);
      if (q > 64'sd2147483647) q = 64'sd2147483647;
      deriv = diff < 0 ? -q : q;
    end
    prev_err = err;
    integral = integ;
    pt = (gain_p * err + (64'sd1 <<< 19)) >>> 20;
    it = (gain_i * integ + (64'sd1 <<< 31)) >>> 32;
    dterm = (gain_d * deriv + (64'sd1 <<< 19)) >>> 20;
    pid = clampl(pt + it + dterm, 0, 65536);
    r.pid = pid[16:0];
    r.drive = 17'(clampl(base + pid, 0, 65536));
    return r;
  endfunction

  assign outstanding = drive_due.size();

  always @(posedge clk) begin
    drive_t e;
    int nerr;
    nerr = 0;
    if (rst) begin
      target = 1600; gain_p = 4294967; gain_i = 2147484; gain_d = 214748;
      base = 26214; dead = 80; thresh = 640; ilimit = 1310720;
      integral = 0; prev_err = 0;
      drive_due.delete();
      errors <= 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_TARGET: target = longint'(cfg_data[14:0]);
          REG_GAIN_P: gain_p = longint'(cfg_data);
          REG_GAIN_I: gain_i = longint'(cfg_data);
          REG_GAIN_D: gain_d = longint'(cfg_data);
          REG_BASE:   base   = longint'(cfg_data[16:0]);
          REG_DEAD:   dead   = longint'(cfg_data[14:0]);
          REG_THRESH: thresh = longint'(cfg_data[14:0]);
          REG_ILIMIT: ilimit = longint'(cfg_data[20:0]);
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (drive_due.size() == 0) begin
          $display("%0t: unexpected result pid_term=%0d drive_level=%0d",
                   $time, pid_term, drive_level);
          nerr = nerr + 1;
        end else begin
          e = drive_due.pop_front();
          if (pid_term !== e.pid) begin
            $display("%0t: pid_term expected %0d actual %0d", $time, e.pid, pid_term);
            nerr = nerr + 1;
          end
          if (drive_level !== e.drive) begin
            $display("%0t: drive_level expected %0d actual %0d",
                     $time, e.drive, drive_level);
            nerr = nerr + 1;
          end
        end
      end
      if (in_valid && in_ready) drive_due.push_back(predict_drive(measured_speed, elapsed_us));
      errors <= errors + nerr;
    end
  end
endmodule

// ----- test/tb_pid_speed_controller.sv -----
// ----------------------------------------------------------------------------
// tb_pid_speed_controller
// Drives speed samples through the PID speed controller under several
// register settings and idling patterns; the checker predicts every result.
// ----------------------------------------------------------------------------
module tb_pid_speed_controller;
  timeunit 1ns;
  timeprecision 1ps;
  import psc_pkg::*;

  localparam int WATCHDOG = 20000;

  logic clk = 0;
  logic rst = 1;
  logic cfg_write = 0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_ready;
  logic signed [15:0] measured_speed = '0;
  logic [19:0] elapsed_us = '0;
  logic out_valid;
  logic out_ready = 0;
  logic [16:0] pid_term, drive_level;
  int errors, outstanding;
  int send_idle = 0, recv_stall = 0;
  int quiet_cycles = 0;
  int cur_target = 1600, cur_thresh = 640;

  always #5 clk = ~clk;

  pid_speed_controller dut (.*);
  pid_drive_checker chk (.*);

  always @(posedge clk) out_ready <= ($urandom_range(99) >= recv_stall);

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send(int spd, int dt);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    measured_speed <= spd[15:0];
    elapsed_us <= dt[19:0];
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic write_settings(logic [CFG_W-1:0] v[8]);
    for (int i = 0; i < 8; i++) begin
      cfg_write <= 1;
      cfg_index <= i[IDX_W-1:0];
      cfg_data <= v[i];
      @(posedge clk);
    end
    cfg_write <= 0;
    cur_target = int'(v[REG_TARGET][14:0]);
    cur_thresh = int'(v[REG_THRESH][14:0]);
  endtask

  function automatic logic [31:0] pick(logic [31:0] hi, logic [31:0] typ);
    case ($urandom_range(5))
      0: return 0;
      1: return hi;
      2: return $urandom;
      default: return typ;
    endcase
  endfunction

  function automatic int near_target();
    int span, s;
    span = cur_thresh + 64;
    s = cur_target + $urandom_range(2 * span) - span;
    return s > 32767 ? 32767 : (s < -32768 ? -32768 : s);
  endfunction

  function automatic int random_dt();
    case ($urandom_range(9))
      0: return 0;
      1: return 1048575;
      2: return $urandom_range(1048575);
      default: return $urandom_range(15000, 25000);
    endcase
  endfunction

  initial begin
    logic [CFG_W-1:0] v[8];
    int spd;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // defaults: deadband, threshold edges, extremes, integral clamp both ways
    send(1600, 20000);
    send(1600 - 79, 20000);
    send(1600 - 80, 20000);
    send(1600 + 80, 20000);
    send(1600 - 640, 20000);
    send(1600 - 641, 20000);
    send(1600 + 641, 0);
    send(-32768, 20000);
    send(32767, 1);
    send(-32768, 1);
    for (int i = 0; i < 4; i++) send(1600 - 600, 1048575);
    for (int i = 0; i < 4; i++) send(1600 + 600, 1048575);
    send(1600 - 300, 0);
    send(1600 - 300, 1);
    send(0, 1048575);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 1) v = '{default: '0};
      else if (ph == 2)
        v = '{32767, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 131071, 32767, 32767, 2097151};
      else if (ph == 3)
        v = '{1600, 100000000, 2000000000, 3000000, 65536, 0, 32767, 2097151};
      else begin
        v[REG_TARGET] = pick(32767, $urandom_range(3200));
        v[REG_GAIN_P] = pick(32'hFFFF_FFFF, $urandom_range(200000000));
        v[REG_GAIN_I] = pick(32'hFFFF_FFFF, $urandom_range(2000000000));
        v[REG_GAIN_D] = pick(32'hFFFF_FFFF, $urandom_range(5000000));
        v[REG_BASE]   = pick(65536, $urandom_range(65536));
        v[REG_DEAD]   = pick(32767, $urandom_range(200));
        v[REG_THRESH] = pick(32767, $urandom_range(100, 2000));
        v[REG_ILIMIT] = pick(2097151, $urandom_range(2097151));
      end
      write_settings(v);
      case (ph % 4)
        0: begin send_idle = 0; recv_stall = 0; end
        1: begin send_idle = 69; recv_stall = 0; end
        2: begin send_idle = 0; recv_stall = 69; end
        default: begin send_idle = 32; recv_stall = 32; end
      endcase
      for (int n = 0; n < 65; n++) begin
        if (ph == 5 && n == 30) begin
          in_valid <= 0;
          @(posedge clk);
          while (outstanding != 0) @(posedge clk);
        end
        if ($urandom_range(9) < 8) spd = near_target();
        else spd = $signed($urandom_range(65535) - 32768);
        send(spd, random_dt());
      end
      send_idle = 0;
      recv_stall = 0;
      drain();
    end

    if (errors == 0 && outstanding == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule
